// ----- src/ldf_pkg.sv -----
package ldf_pkg;

    localparam int unsigned QAw    = 2;
    localparam int unsigned QDepth = 1 << QAw;
    localparam int unsigned QCw    = QAw + 1;

    localparam logic KindData = 1'b0;
    localparam logic KindDrop = 1'b1;

    localparam logic [31:0] MaxPayloadReset = 32'hFFFF_FFFF;

    typedef enum logic [2:0] {
        PhLen0    = 3'd0,
        PhLen1    = 3'd1,
        PhLen2    = 3'd2,
        PhLen3    = 3'd3,
        PhPayload = 3'd4
    } t_phase;

    typedef struct packed {
        logic [7:0]  payload_byte;
        logic        last_byte;
        logic        length_error;
        logic [31:0] packet_length;
    } t_result;

endpackage

// ----- src/ldf_front.sv -----
module ldf_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_accept,
    input  logic              i_kind,
    input  logic [7:0]        i_rx_byte,
    input  logic              i_cfg_write,
    input  logic [31:0]       i_cfg_max_payload,
    output logic              o_push,
    output ldf_pkg::t_result  o_entry
);

    ldf_pkg::t_phase r_phase, n_phase;
    logic [31:0]     r_length, n_length;
    logic [31:0]     r_count, n_count;
    logic [31:0]     r_max;

    logic [31:0] w_byte_ext;
    logic [31:0] w_full_len;
    logic [31:0] w_count_inc;
    logic        w_last;

    assign w_byte_ext  = {24'd0, i_rx_byte};
    assign w_full_len  = {i_rx_byte, r_length[23:0]};
    assign w_count_inc = r_count + 32'd1;
    assign w_last      = (w_count_inc >= r_length);

    always_comb begin
        n_phase = r_phase;
        if (i_accept) begin
            if (i_kind == ldf_pkg::KindDrop) begin
                n_phase = ldf_pkg::PhLen0;
            end else begin
                case (r_phase)
                    ldf_pkg::PhLen0: n_phase = ldf_pkg::PhLen1;
                    ldf_pkg::PhLen1: n_phase = ldf_pkg::PhLen2;
                    ldf_pkg::PhLen2: n_phase = ldf_pkg::PhLen3;
                    ldf_pkg::PhLen3: begin
                        if (w_full_len == 32'd0 || w_full_len > r_max) begin
                            n_phase = ldf_pkg::PhLen0;
                        end else begin
                            n_phase = ldf_pkg::PhPayload;
                        end
                    end
                    ldf_pkg::PhPayload: begin
                        if (w_last) begin
                            n_phase = ldf_pkg::PhLen0;
                        end
                    end
                    default: n_phase = ldf_pkg::PhLen0;
                endcase
            end
        end
    end

    always_comb begin
        o_push                = 1'b0;
        o_entry.payload_byte  = 8'd0;
        o_entry.last_byte     = 1'b0;
        o_entry.length_error  = 1'b0;
        o_entry.packet_length = r_length;
        n_length              = r_length;
        n_count               = r_count;
        if (i_accept) begin
            if (i_kind == ldf_pkg::KindDrop) begin
                n_length = 32'd0;
                n_count  = 32'd0;
            end else begin
                case (r_phase)
                    ldf_pkg::PhLen0: n_length = w_byte_ext;
                    ldf_pkg::PhLen1: n_length = r_length | (w_byte_ext << 8);
                    ldf_pkg::PhLen2: n_length = r_length | (w_byte_ext << 16);
                    ldf_pkg::PhLen3: begin
                        n_count = 32'd0;
                        if (w_full_len != 32'd0 && w_full_len > r_max) begin
                            // Oversized packet: report it and start a fresh header.
                            o_push                = 1'b1;
                            o_entry.length_error  = 1'b1;
                            o_entry.packet_length = w_full_len;
                            n_length              = 32'd0;
                        end else begin
                            n_length = w_full_len;
                        end
                    end
                    ldf_pkg::PhPayload: begin
                        o_push               = 1'b1;
                        o_entry.payload_byte = i_rx_byte;
                        o_entry.last_byte    = w_last;
                        n_count              = w_count_inc;
                    end
                    default: begin
                        n_length = 32'd0;
                        n_count  = 32'd0;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= ldf_pkg::PhLen0;
            r_length <= 32'd0;
            r_count  <= 32'd0;
            r_max    <= ldf_pkg::MaxPayloadReset;
        end else begin
            r_phase  <= n_phase;
            r_length <= n_length;
            r_count  <= n_count;
            if (i_cfg_write) begin
                r_max <= i_cfg_max_payload;
            end
        end
    end

    a_err_restarts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_push && o_entry.length_error) |=> (r_phase == ldf_pkg::PhLen0 && r_length == 32'd0))
        else $error("length error did not restart the parser");

    a_data_in_payload: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_push && !o_entry.length_error) |-> (r_phase == ldf_pkg::PhPayload))
        else $error("payload item produced outside the payload phase");

endmodule

// ----- src/ldf_queue.sv -----
module ldf_queue (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  ldf_pkg::t_result  i_entry,
    input  logic              i_pop,
    output logic              o_full,
    output logic              o_valid,
    output ldf_pkg::t_result  o_entry
);

    ldf_pkg::t_result                r_mem [ldf_pkg::QDepth];
    logic [ldf_pkg::QAw-1:0]         r_wr_ptr, n_wr_ptr;
    logic [ldf_pkg::QAw-1:0]         r_rd_ptr, n_rd_ptr;
    logic [ldf_pkg::QCw-1:0]         r_count, n_count;

    logic w_do_push;
    logic w_do_pop;

    assign o_full    = (r_count == ldf_pkg::QCw'(ldf_pkg::QDepth));
    assign o_valid   = (r_count != '0);
    assign o_entry   = r_mem[r_rd_ptr];
    assign w_do_push = i_push && !o_full;
    assign w_do_pop  = i_pop && o_valid;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (w_do_push) begin
            n_wr_ptr = r_wr_ptr + 1'b1;
        end
        if (w_do_pop) begin
            n_rd_ptr = r_rd_ptr + 1'b1;
        end
        case ({w_do_push, w_do_pop})
            2'b10:   n_count = r_count + 1'b1;
            2'b01:   n_count = r_count - 1'b1;
            default: n_count = r_count;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_do_push) begin
            r_mem[r_wr_ptr] <= i_entry;
        end
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= ldf_pkg::QCw'(ldf_pkg::QDepth))
        else $error("queue count beyond its depth");

    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_full |-> !i_push)
        else $error("item pushed into a full queue");

endmodule

// ----- src/ldf_back.sv -----
module ldf_back (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_q_valid,
    input  ldf_pkg::t_result  i_q_entry,
    output logic              o_pop,
    input  logic              i_out_stall,
    output logic              o_out_valid,
    output ldf_pkg::t_result  o_out_entry
);

    logic             r_valid, n_valid;
    ldf_pkg::t_result r_entry;

    // The output register reloads whenever it is empty or being taken.
    assign o_pop = i_q_valid && (!r_valid || !i_out_stall);

    always_comb begin
        n_valid = r_valid;
        if (o_pop) begin
            n_valid = 1'b1;
        end else if (!i_out_stall) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_entry <= i_q_entry;
        end
    end

    assign o_out_valid = r_valid;
    assign o_out_entry = r_entry;

    a_pop_fills: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop |=> r_valid)
        else $error("output register empty after a load");

endmodule

// ----- src/length_prefix_deframer_unit.sv -----
// Length-prefixed deframer. Each packet on the input byte stream is a
// four-byte little-endian length followed by that many payload bytes.
// Input channel: i_in_valid / o_in_stall with i_kind (0 data byte,
// 1 connection dropped) and i_rx_byte. Output channel: o_out_valid /
// i_out_stall with o_payload_byte, o_last_byte, o_length_error and
// o_packet_length. Header bytes, drops and zero-length packets give no
// item; a length above max_payload gives one error item.
// Configuration: i_cfg_valid / o_cfg_ready with i_cfg_max_payload; ready
// is always high and the register should only be written while idle.
// Throughput is one item per cycle while o_in_stall is low. A result is
// written into the four-entry queue at the edge that accepts its input item
// and then moves through the queue into the output register, from which the
// receiver takes it. When the receiver stalls, the output holds and
// the queue fills; o_in_stall rises once the queue holds four results.
// Synchronous reset clears the parser to await the first length byte,
// empties the queue and sets max_payload to all ones.
module length_prefix_deframer_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic        i_kind,
    input  logic [7:0]  i_rx_byte,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [7:0]  o_payload_byte,
    output logic        o_last_byte,
    output logic        o_length_error,
    output logic [31:0] o_packet_length,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [31:0] i_cfg_max_payload
);

    logic             w_accept;
    logic             w_push;
    ldf_pkg::t_result w_push_entry;
    logic             w_q_full;
    logic             w_q_valid;
    ldf_pkg::t_result w_q_entry;
    logic             w_pop;
    ldf_pkg::t_result w_out_entry;

    assign o_cfg_ready = 1'b1;
    assign o_in_stall  = w_q_full;
    assign w_accept    = i_in_valid && !w_q_full;

    ldf_front u_front (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_accept          (w_accept),
        .i_kind            (i_kind),
        .i_rx_byte         (i_rx_byte),
        .i_cfg_write       (i_cfg_valid),
        .i_cfg_max_payload (i_cfg_max_payload),
        .o_push            (w_push),
        .o_entry           (w_push_entry)
    );

    ldf_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_entry (w_push_entry),
        .i_pop   (w_pop),
        .o_full  (w_q_full),
        .o_valid (w_q_valid),
        .o_entry (w_q_entry)
    );

    ldf_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_valid   (w_q_valid),
        .i_q_entry   (w_q_entry),
        .o_pop       (w_pop),
        .i_out_stall (i_out_stall),
        .o_out_valid (o_out_valid),
        .o_out_entry (w_out_entry)
    );

    assign o_payload_byte  = w_out_entry.payload_byte;
    assign o_last_byte     = w_out_entry.last_byte;
    assign o_length_error  = w_out_entry.length_error;
    assign o_packet_length = w_out_entry.packet_length;

endmodule

// ----- sim/length_prefix_deframer_unit_test.sv -----
module length_prefix_deframer_unit_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CLK_PERIOD   = 10;
    localparam int RESET_CYCLES = 7;
    localparam int SETTLE       = 4;
    localparam int QUIET_LIMIT  = 1000;
    localparam int NUM_PHASES   = 5;
    localparam int PHASE_ITEMS  = 205;

    // Mirrors the deframer: parse state, the length limit and the queue of
    // output items that are still owed.
    class deframe_scoreboard;
        logic [31:0]      max_payload;
        ldf_pkg::t_phase  parse_phase;
        logic [31:0]      length_word;
        logic [31:0]      payload_count;
        ldf_pkg::t_result owed_q[$];
        int               mismatches;

        function new();
            max_payload = ldf_pkg::MaxPayloadReset;
            mismatches  = 0;
            drop_frame();
        endfunction

        function void drop_frame();
            parse_phase   = ldf_pkg::PhLen0;
            length_word   = '0;
            payload_count = '0;
        endfunction

        function void note_rx_item(input logic kind, input logic [7:0] rx);
            ldf_pkg::t_result res;
            if (kind == ldf_pkg::KindDrop) begin
                drop_frame();
                return;
            end
            case (parse_phase)
                ldf_pkg::PhLen0: begin
                    length_word = {24'd0, rx};
                    parse_phase = ldf_pkg::PhLen1;
                end
                ldf_pkg::PhLen1: begin
                    length_word[15:8] = rx;
                    parse_phase = ldf_pkg::PhLen2;
                end
                ldf_pkg::PhLen2: begin
                    length_word[23:16] = rx;
                    parse_phase = ldf_pkg::PhLen3;
                end
                ldf_pkg::PhLen3: begin
                    length_word[31:24] = rx;
                    payload_count = '0;
                    if (length_word == '0) begin
                        parse_phase = ldf_pkg::PhLen0;
                    end else if (length_word > max_payload) begin
                        res = ldf_pkg::t_result'{8'd0, 1'b0, 1'b1, length_word};
                        owed_q.push_back(res);
                        drop_frame();
                    end else begin
                        parse_phase = ldf_pkg::PhPayload;
                    end
                end
                ldf_pkg::PhPayload: begin
                    payload_count++;
                    res = ldf_pkg::t_result'{rx, payload_count >= length_word,
                                             1'b0, length_word};
                    owed_q.push_back(res);
                    if (res.last_byte) begin
                        parse_phase = ldf_pkg::PhLen0;
                    end
                end
                default: drop_frame();
            endcase
        endfunction

        task report_mismatch(input string what);
            mismatches++;
            $display("%0t ns: mismatch: %s", $time, what);
        endtask

        task check_out_item(input ldf_pkg::t_result got);
            ldf_pkg::t_result want;
            if (owed_q.size() == 0) begin
                report_mismatch($sformatf("output item with none owed: %p", got));
                return;
            end
            want = owed_q.pop_front();
            if (got.payload_byte !== want.payload_byte)
                report_mismatch($sformatf("payload_byte %h, wanted %h",
                                          got.payload_byte, want.payload_byte));
            if (got.last_byte !== want.last_byte)
                report_mismatch($sformatf("last_byte %b, wanted %b",
                                          got.last_byte, want.last_byte));
            if (got.length_error !== want.length_error)
                report_mismatch($sformatf("length_error %b, wanted %b",
                                          got.length_error, want.length_error));
            if (got.packet_length !== want.packet_length)
                report_mismatch($sformatf("packet_length %h, wanted %h",
                                          got.packet_length, want.packet_length));
        endtask
    endclass

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_in_valid = 1'b0;
    logic        o_in_stall;
    logic        i_kind = ldf_pkg::KindData;
    logic [7:0]  i_rx_byte = 8'd0;
    logic        o_out_valid;
    logic        i_out_stall = 1'b0;
    logic [7:0]  o_payload_byte;
    logic        o_last_byte;
    logic        o_length_error;
    logic [31:0] o_packet_length;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [31:0] i_cfg_max_payload = 32'd0;

    deframe_scoreboard sb = new();

    int          gap_pct = 20;
    int          stall_pct = 10;
    int unsigned items_sent = 0;
    int          quiet_cycles = 0;

    length_prefix_deframer_unit u_dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .o_in_stall       (o_in_stall),
        .i_kind           (i_kind),
        .i_rx_byte        (i_rx_byte),
        .o_out_valid      (o_out_valid),
        .i_out_stall      (i_out_stall),
        .o_payload_byte   (o_payload_byte),
        .o_last_byte      (o_last_byte),
        .o_length_error   (o_length_error),
        .o_packet_length  (o_packet_length),
        .i_cfg_valid      (i_cfg_valid),
        .o_cfg_ready      (o_cfg_ready),
        .i_cfg_max_payload(i_cfg_max_payload)
    );

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    // Any accepted item on any channel counts as progress.
    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall) ||
            (i_cfg_valid && o_cfg_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("length_prefix_deframer_unit_test: done, errors");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid === 1'b1 && !i_out_stall) begin
            sb.check_out_item(ldf_pkg::t_result'{o_payload_byte, o_last_byte,
                                                 o_length_error, o_packet_length});
        end
    end

    initial begin
        forever begin
            @(posedge i_clk);
            if (stall_pct != 0 && $urandom_range(1, 100) <= stall_pct) begin
                i_out_stall <= 1'b1;
                repeat ($urandom_range(1, 11)) @(posedge i_clk);
                i_out_stall <= 1'b0;
            end
        end
    end

    task automatic push_item(input logic kind, input logic [7:0] rx);
        if (gap_pct != 0 && $urandom_range(1, 100) <= gap_pct) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 11)) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_kind     <= kind;
        i_rx_byte  <= rx;
        do @(posedge i_clk); while (o_in_stall !== 1'b0);
        sb.note_rx_item(kind, rx);
        items_sent++;
    endtask

    task automatic push_random_byte();
        push_item(ldf_pkg::KindData, 8'($urandom_range(0, 255)));
    endtask

    task automatic push_drop();
        push_item(ldf_pkg::KindDrop, 8'($urandom_range(0, 255)));
    endtask

    task automatic send_header(input logic [31:0] len);
        for (int i = 0; i < 4; i++) begin
            push_item(ldf_pkg::KindData, 8'(len >> (8 * i)));
        end
    endtask

    // The limit may only change with the block drained; header bytes leave
    // nothing owed, so the SETTLE wait covers an item still in flight.
    task automatic write_max_payload(input logic [31:0] limit);
        i_in_valid <= 1'b0;
        while (sb.owed_q.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
        i_cfg_valid       <= 1'b1;
        i_cfg_max_payload <= limit;
        do @(posedge i_clk); while (o_cfg_ready !== 1'b1);
        i_cfg_valid <= 1'b0;
        sb.max_payload = limit;
    endtask

    task automatic random_episode();
        int unsigned pick;
        int unsigned cut;
        logic [31:0] len;
        pick = $urandom_range(0, 99);
        if (pick < 70) begin
            len = ($urandom_range(0, 9) == 0) ? $urandom_range(25, 200)
                                              : $urandom_range(0, 24);
            send_header(len);
            if (len != 0 && len <= sb.max_payload) begin
                repeat (len) push_random_byte();
            end
        end else if (pick < 80) begin
            // A wild length: an error under a tight limit, otherwise the
            // packet is cut short by a disconnect.
            len = $urandom();
            send_header(len);
            if (len != 0 && len <= sb.max_payload) begin
                repeat ($urandom_range(0, 6)) push_random_byte();
                push_drop();
            end
        end else if (pick < 88) begin
            len = $urandom_range(2, 24);
            cut = $urandom_range(0, len + 2);
            for (int i = 0; i < cut; i++) begin
                if (i < 4) begin
                    push_item(ldf_pkg::KindData, 8'(len >> (8 * i)));
                end else begin
                    push_random_byte();
                end
            end
            push_drop();
        end else if (pick < 95) begin
            push_drop();
        end else begin
            repeat ($urandom_range(1, 6)) push_random_byte();
            push_drop();
        end
    endtask

    initial begin
        logic [31:0] phase_max [NUM_PHASES];
        int unsigned goal;

        phase_max[0] = 32'd0;
        phase_max[1] = 32'hFFFF_FFFF;
        phase_max[2] = 32'd1;
        phase_max[3] = $urandom_range(2, 40);
        phase_max[4] = $urandom_range(8, 30);

        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Short packet carrying both extreme byte values, then an empty one.
        send_header(32'd2);
        push_item(ldf_pkg::KindData, 8'h00);
        push_item(ldf_pkg::KindData, 8'hFF);
        send_header(32'd0);
        // Disconnect part way through a header.
        push_item(ldf_pkg::KindData, 8'h05);
        push_item(ldf_pkg::KindDrop, 8'hFF);
        // Largest length, equal to the reset limit, cut short by a disconnect.
        send_header(32'hFFFF_FFFF);
        push_item(ldf_pkg::KindData, 8'hA5);
        push_item(ldf_pkg::KindDrop, 8'h00);
        // One over the limit, then exactly at it.
        write_max_payload(32'd1);
        send_header(32'd2);
        send_header(32'd1);
        push_item(ldf_pkg::KindData, 8'h5A);

        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            if (ph == NUM_PHASES - 1) begin
                gap_pct   = 0;
                stall_pct = 0;
            end else begin
                gap_pct   = $urandom_range(5, 30);
                stall_pct = $urandom_range(3, 15);
            end
            write_max_payload(phase_max[ph]);
            goal = items_sent + PHASE_ITEMS;
            while (items_sent < goal) random_episode();
        end

        i_in_valid <= 1'b0;
        while (sb.owed_q.size() != 0) @(posedge i_clk);
        repeat (2 * SETTLE) @(posedge i_clk);
        if (sb.mismatches == 0) begin
            $display("length_prefix_deframer_unit_test: done, clean");
        end else begin
            $display("length_prefix_deframer_unit_test: done, errors");
        end
        $finish;
    end

endmodule
